// ===== design/srlm_pkg.sv =====
// shared types and constants of the step response level meter
`default_nettype none
package srlm_pkg;

  localparam int unsigned NUM_WINDOWS_DEF = 8;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned WIN_IDX_W       = 6;
  localparam int unsigned MAG_W           = 15;
  localparam int unsigned RATIO_W         = 22;
  localparam int unsigned SUM_W           = 32;
  localparam int unsigned CNT_W           = 16;

  localparam logic [MAG_W-1:0]   MAG_MAX       = 15'h7FFF;
  localparam logic [MAG_W-1:0]   TRIGGER_LEVEL = 15'd50;
  localparam logic [6:0]         PERCENT       = 7'd100;
  localparam logic [TIME_W-1:0]  FIRST_TRIM    = 32'd4;
  localparam logic [CFG_W-1:0]   FIRST_WIN_RST = 16'd100;
  localparam logic [CFG_W-1:0]   WINDOW_RST    = 16'd100;
  localparam logic [CFG_W-1:0]   RELAX_RST     = 16'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_WINDOW = 2'd0,
    CFG_WINDOW       = 2'd1,
    CFG_RELAX        = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_START  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_WINDOW = 2'd1,
    PH_RELAX  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_WR,
    ST_RPT_RD,
    ST_RPT_AVG,
    ST_RPT_AVG_WAIT,
    ST_RPT_MUL,
    ST_RPT_RATIO,
    ST_RPT_OUT
  } state_e;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ===== design/srlm_if.sv =====
// request, result and register write channels
`default_nettype none
interface srlm_req_if;
  import srlm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [SAMPLE_W-1:0] sample;
  logic [TIME_W-1:0]          elapsed_ms;
  modport source (output valid, req_type, sample, elapsed_ms, input ready);
  modport sink   (input valid, req_type, sample, elapsed_ms, output ready);
endinterface

interface srlm_res_if;
  import srlm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WIN_IDX_W-1:0] window_index;
  logic [MAG_W-1:0]     average;
  logic [RATIO_W-1:0]   ratio_percent;
  logic                 last_window;
  modport source (output valid, window_index, average, ratio_percent, last_window,
                  input ready);
  modport sink   (input valid, window_index, average, ratio_percent, last_window,
                  output ready);
endinterface

interface srlm_cfg_if;
  import srlm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/srlm_mem.sv =====
// per-window sum and count store with registered read and per-entry valid bits
`default_nettype none
module srlm_mem #(
  parameter int unsigned DEPTH = srlm_pkg::NUM_WINDOWS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire srlm_pkg::mem_ctl_t       ctl_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire srlm_pkg::entry_t         wr_data_i,
  output      srlm_pkg::entry_t         rd_data_o
);
  import srlm_pkg::*;

  entry_t           mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  entry_t           rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.clr) begin
      valid_q <= '0;
    end else if (ctl_i.wr_en) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // an entry never written since the last start reads as zero
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== design/srlm_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module srlm_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire srlm_pkg::div_req_t            req_i,
  output      logic                          done_o,
  output      logic [srlm_pkg::SUM_W-1:0]    quot_o
);
  import srlm_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  quot_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W:0]    shifted;
  logic              fits;

  assign shifted = {rem_q, quot_q[SUM_W-1]};
  assign fits    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      div_q  <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[SUM_W-2:0], fits};
      rem_q  <= fits ? CNT_W'(shifted - {1'b0, div_q}) : shifted[CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ===== design/step_response_level_meter.sv =====
// step response level meter: windowed magnitude averages after a trigger
// a start or a non-accumulating sample is handled in the idle state, an accumulating
// sample in idle and the write state (one read-modify-write of the window memory);
// no new request is taken meanwhile; the report after the last window runs each window
// through the shared 32-step divider for the average and, where needed, for the ratio
// reset (asynchronous, active low) restores register defaults and clears all windows
`default_nettype none
module step_response_level_meter #(
  parameter int unsigned NUM_WINDOWS = srlm_pkg::NUM_WINDOWS_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  srlm_req_if.sink   req_i,
  srlm_res_if.source res_o,
  srlm_cfg_if.sink   cfg_i
);
  import srlm_pkg::*;

  localparam int unsigned WIN_W = $clog2(NUM_WINDOWS);
  localparam logic [WIN_W-1:0] LAST_WIN = WIN_W'(NUM_WINDOWS - 1);

  state_e state_q, state_d;
  phase_e phase_q;

  logic [CFG_W-1:0]  first_q, window_q, relax_q;
  logic [WIN_W-1:0]  cur_win_q, rpt_w_q;
  logic [TIME_W-1:0] win_end_q, relax_end_q;
  logic [MAG_W-1:0]  mag_q, avg_q, ref_q;
  logic [RATIO_W-1:0] ratio_q;

  logic               res_valid_q;
  logic [WIN_IDX_W-1:0] res_idx_q;
  logic [MAG_W-1:0]   res_avg_q;
  logic [RATIO_W-1:0] res_ratio_q;
  logic               res_last_q;

  // request decode
  logic              req_acc, is_sample;
  logic [SAMPLE_W-1:0] neg;
  logic [SAMPLE_W-1:0] abs_val;
  logic [MAG_W-1:0]  mag;
  logic [TIME_W-1:0] tick;
  logic              win_close, relax_over, trig;

  mem_ctl_t          mem_ctl;
  logic [WIN_W-1:0]  rd_addr;
  entry_t            rd_data, wr_data;
  logic [SUM_W:0]    sum_ext;
  div_req_t          div_req;
  logic              div_done;
  logic [SUM_W-1:0]  div_quot;
  logic [MAG_W-1:0]  quot_clamp;
  logic              out_free, res_load, req_ready;

  assign req_acc   = req_i.valid && req_ready;
  assign is_sample = req_i.req_type == REQ_SAMPLE;
  assign neg       = SAMPLE_W'(~req_i.sample) + 1'b1;
  assign abs_val   = req_i.sample[SAMPLE_W-1] ? neg : req_i.sample;
  // the most negative reading saturates
  assign mag       = abs_val[SAMPLE_W-1] ? MAG_MAX : abs_val[MAG_W-1:0];
  assign tick      = req_i.elapsed_ms;
  assign win_close  = tick >= win_end_q;
  assign relax_over = tick >= relax_end_q;
  assign trig       = mag > TRIGGER_LEVEL;

  assign out_free   = !res_valid_q || res_o.ready;
  assign quot_clamp = (|div_quot[SUM_W-1:MAG_W]) ? MAG_MAX : div_quot[MAG_W-1:0];

  // saturating accumulate
  assign sum_ext       = {1'b0, rd_data.sum} + (SUM_W+1)'(mag_q);
  assign wr_data.sum   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign wr_data.count = (&rd_data.count) ? rd_data.count : rd_data.count + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc && is_sample && phase_q == PH_WINDOW) begin
          if (!win_close) begin
            state_d = ST_ACC_WR;
          end else if (cur_win_q == LAST_WIN) begin
            state_d = ST_RPT_RD;
          end
        end
      end
      ST_ACC_WR:  state_d = ST_IDLE;
      ST_RPT_RD:  state_d = ST_RPT_AVG;
      ST_RPT_AVG: state_d = (rd_data.count == '0) ? ST_RPT_OUT : ST_RPT_AVG_WAIT;
      ST_RPT_AVG_WAIT: begin
        if (div_done) begin
          state_d = (rpt_w_q == '0 || ref_q == '0) ? ST_RPT_OUT : ST_RPT_MUL;
        end
      end
      ST_RPT_MUL: state_d = ST_RPT_RATIO;
      ST_RPT_RATIO: begin
        if (div_done) begin
          state_d = ST_RPT_OUT;
        end
      end
      ST_RPT_OUT: begin
        if (out_free) begin
          state_d = (rpt_w_q == LAST_WIN) ? ST_IDLE : ST_RPT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready        = 1'b0;
    mem_ctl          = '0;
    rd_addr          = cur_win_q;
    div_req.start    = 1'b0;
    div_req.dividend = rd_data.sum;
    div_req.divisor  = rd_data.count;
    res_load         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready     = 1'b1;
        mem_ctl.rd_en = 1'b1;
        mem_ctl.clr   = req_acc && !is_sample;
      end
      ST_ACC_WR: mem_ctl.wr_en = 1'b1;
      ST_RPT_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = rpt_w_q;
      end
      ST_RPT_AVG: div_req.start = rd_data.count != '0;
      ST_RPT_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = SUM_W'(avg_q * PERCENT);
        div_req.divisor  = CNT_W'(ref_q);
      end
      ST_RPT_OUT: res_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= FIRST_WIN_RST;
      window_q <= WINDOW_RST;
      relax_q  <= RELAX_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FIRST_WINDOW: first_q  <= cfg_i.data;
        CFG_WINDOW:       window_q <= cfg_i.data;
        CFG_RELAX:        relax_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // measurement sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      cur_win_q   <= '0;
      win_end_q   <= '0;
      relax_end_q <= '0;
      rpt_w_q     <= '0;
    end else begin
      if (req_acc && !is_sample) begin
        phase_q     <= PH_WAIT;
        cur_win_q   <= '0;
        win_end_q   <= '0;
        relax_end_q <= '0;
      end else if (req_acc) begin
        case (phase_q)
          PH_WAIT: begin
            if (trig) begin
              win_end_q   <= tick + TIME_W'(first_q) - FIRST_TRIM;
              relax_end_q <= '0;
              cur_win_q   <= '0;
              phase_q     <= PH_WINDOW;
            end
          end
          PH_WINDOW: begin
            if (win_close) begin
              if (cur_win_q == LAST_WIN) begin
                phase_q <= PH_DONE;
                rpt_w_q <= '0;
              end else begin
                cur_win_q   <= cur_win_q + 1'b1;
                phase_q     <= PH_RELAX;
                relax_end_q <= tick + TIME_W'(relax_q);
              end
            end
          end
          PH_RELAX: begin
            if (relax_over) begin
              phase_q   <= PH_WINDOW;
              win_end_q <= tick + TIME_W'(window_q);
            end
          end
          default: ;
        endcase
      end
      if (res_load && rpt_w_q != LAST_WIN) begin
        rpt_w_q <= rpt_w_q + 1'b1;
      end
    end
  end

  // report datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      mag_q <= mag;
    end
    case (state_q)
      ST_RPT_AVG: begin
        if (rd_data.count == '0) begin
          avg_q   <= '0;
          ratio_q <= '0;
          if (rpt_w_q == '0) begin
            ref_q <= '0;
          end
        end
      end
      ST_RPT_AVG_WAIT: begin
        if (div_done) begin
          avg_q <= quot_clamp;
          if (rpt_w_q == '0) begin
            ref_q   <= quot_clamp;
            ratio_q <= RATIO_W'(PERCENT);
          end else if (ref_q == '0) begin
            ratio_q <= '0;
          end
        end
      end
      ST_RPT_RATIO: begin
        if (div_done) begin
          ratio_q <= div_quot[RATIO_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_idx_q   <= WIN_IDX_W'(rpt_w_q);
      res_avg_q   <= avg_q;
      res_ratio_q <= ratio_q;
      res_last_q  <= rpt_w_q == LAST_WIN;
    end
  end

  assign req_i.ready         = req_ready;
  assign res_o.valid         = res_valid_q;
  assign res_o.window_index  = res_idx_q;
  assign res_o.average       = res_avg_q;
  assign res_o.ratio_percent = res_ratio_q;
  assign res_o.last_window   = res_last_q;

  srlm_mem #(
    .DEPTH(NUM_WINDOWS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(cur_win_q),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  srlm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(div_quot)
  );

endmodule
`default_nettype wire

// ===== design/srlm_chk.sv =====
// port checker for the step response level meter and its bind
`default_nettype none
module srlm_chk #(
  parameter int unsigned NUM_WINDOWS = srlm_pkg::NUM_WINDOWS_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            res_valid_i,
  input wire logic                            res_ready_i,
  input wire logic [srlm_pkg::WIN_IDX_W-1:0]  res_index_i,
  input wire logic [srlm_pkg::RATIO_W-1:0]    res_ratio_i,
  input wire logic                            res_last_i
);
  import srlm_pkg::*;

  localparam logic [WIN_IDX_W-1:0] LAST_IDX = WIN_IDX_W'(NUM_WINDOWS - 1);

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_index_i)
      && $stable(res_ratio_i))
    else $error("stalled result changed");

  a_last_is_final_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_last_i == (res_index_i == LAST_IDX)))
    else $error("last window flag does not match index");

  a_first_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_index_i == '0 |->
      res_ratio_i == RATIO_W'(PERCENT) || res_ratio_i == '0)
    else $error("window 0 ratio is neither 100 nor 0");

endmodule

bind step_response_level_meter srlm_chk #(
  .NUM_WINDOWS(NUM_WINDOWS)
) u_srlm_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .res_index_i(res_o.window_index),
  .res_ratio_i(res_o.ratio_percent),
  .res_last_i (res_o.last_window)
);
`default_nettype wire
